FILE: rtl/ror_pkg.sv
`timescale 1ns / 1ps

package ror_pkg;

  localparam int unsigned X_W   = 7;
  localparam int unsigned Y_W   = 5;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned LIM_W = 4;
  localparam int unsigned SQ_W  = 14;  // square of an 8-bit signed offset
  localparam int unsigned DIST_W = SQ_W + 1;
  localparam int unsigned LO_W  = 8;
  localparam int unsigned HI_W  = 9;

  localparam logic [SYM_W-1:0] BG_RESET = 8'd32;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef struct packed {
    logic [X_W-1:0]   cx;
    logic [Y_W-1:0]   cy;
    logic [LIM_W-1:0] radius;
    logic [LIM_W-1:0] limit;
    logic [SYM_W-1:0] symbol;
  } ring_entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic issue;
    logic finish;
  } ror_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic last_issue;
    logic pipe_empty;
  } ror_stat_t;

  // inner bound (r-1)^2; a zero radius still needs distance 1
  function automatic logic [LO_W-1:0] ring_lo(input logic [LIM_W-1:0] r);
    logic [LIM_W-1:0] d;
    d = (r == '0) ? LIM_W'(1) : r - LIM_W'(1);
    return {4'b0, d} * {4'b0, d};
  endfunction

  // outer bound (r+1)^2
  function automatic logic [HI_W-1:0] ring_hi(input logic [LIM_W-1:0] r);
    logic [LIM_W:0] e;
    e = {1'b0, r} + 5'd1;
    return {4'b0, e} * {4'b0, e};
  endfunction

endpackage

FILE: rtl/ring_overlay_rasterizer.sv
`timescale 1ns / 1ps

// Ring overlay rasterizer. Pulse start with an opcode while busy is low. Add and
// clear complete without raising busy. Tick and pixel query read the ring table
// one entry per cycle through its single read port, and busy stays high until
// the walk has drained. A query answers with out_valid high for exactly one
// cycle, the first cycle with busy low again; the result is not held, so the
// receiver must take it in that cycle. Add, clear and tick give no result. The
// background symbol is to be written by the user through cfg_valid/cfg_data
// only while idle; the block itself does not enforce this.
module ring_overlay_rasterizer #(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned FIELD_WIDTH  = 80,
  parameter int unsigned FIELD_HEIGHT = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_opcode,
  input  logic [6:0] in_coord_x,
  input  logic [4:0] in_coord_y,
  input  logic [7:0] in_ring_symbol,
  input  logic [3:0] in_ring_limit,
  output logic       out_valid,
  output logic [7:0] out_pixel_symbol,
  output logic       out_ring_hit,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  ror_pkg::ror_cmd_t  cmd;
  ror_pkg::ror_stat_t stat;

  assign cfg_ready = 1'b1;

  ror_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  ror_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .FIELD_WIDTH  (FIELD_WIDTH),
    .FIELD_HEIGHT (FIELD_HEIGHT)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_ring_symbol   (in_ring_symbol),
    .in_ring_limit    (in_ring_limit),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_pixel_symbol (out_pixel_symbol),
    .out_ring_hit     (out_ring_hit)
  );

endmodule

FILE: rtl/ror_ctrl.sv
`timescale 1ns / 1ps

module ror_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_opcode,
  input  ror_pkg::ror_stat_t stat,
  output ror_pkg::ror_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  ror_pkg::op_t  op;

  assign op = ror_pkg::op_t'(in_opcode);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (op inside {ror_pkg::OP_TICK, ror_pkg::OP_QUERY}) begin
            state_nxt = stat.count_zero ? ST_DRAIN : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last entry to leave the pipeline, then commit
        if (stat.pipe_empty) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: rtl/ror_datapath.sv
`timescale 1ns / 1ps

module ror_datapath #(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned FIELD_WIDTH  = 80,
  parameter int unsigned FIELD_HEIGHT = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ror_pkg::ror_cmd_t         cmd,
  output ror_pkg::ror_stat_t        stat,
  input  logic [1:0]                in_opcode,
  input  logic [ror_pkg::X_W-1:0]   in_coord_x,
  input  logic [ror_pkg::Y_W-1:0]   in_coord_y,
  input  logic [ror_pkg::SYM_W-1:0] in_ring_symbol,
  input  logic [ror_pkg::LIM_W-1:0] in_ring_limit,
  input  logic                      cfg_wr,
  input  logic [ror_pkg::SYM_W-1:0] cfg_data,
  output logic                      out_valid,
  output logic [ror_pkg::SYM_W-1:0] out_pixel_symbol,
  output logic                      out_ring_hit
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW = AW + 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(TABLE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(TABLE_DEPTH - 1);

  // logical table position to physical slot of the circular buffer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] ofs);
    logic [PW-1:0] s;
    s = {1'b0, base} + PW'(ofs);
    if (s >= DEPTH_P) s = s - DEPTH_P;
    return s[AW-1:0];
  endfunction

  ror_pkg::ring_entry_t ring_mem [TABLE_DEPTH];

  ror_pkg::op_t              op;
  logic [CW-1:0]             count_r, count_nxt;
  logic [AW-1:0]             head_r, head_nxt;
  logic [ror_pkg::SYM_W-1:0] bg_r;
  logic [CW-1:0]             idx_r, kept_r;
  logic                      query_r, field_ok_r;
  logic [ror_pkg::X_W-1:0]   px_r;
  logic [ror_pkg::Y_W-1:0]   py_r;
  ror_pkg::ring_entry_t      rd_r;
  logic                      v1_r, v2_r;
  logic [ror_pkg::SQ_W-1:0]  dx2_r, dy2_r;
  logic [ror_pkg::LO_W-1:0]  lo_r;
  logic [ror_pkg::HI_W-1:0]  hi_r;
  logic [ror_pkg::SYM_W-1:0] sym2_r, hsym_r;
  logic                      hit_r;
  logic                      out_valid_r, out_hit_r;
  logic [ror_pkg::SYM_W-1:0] out_sym_r;

  logic                      full;
  logic                      we;
  logic [AW-1:0]             waddr;
  ror_pkg::ring_entry_t      wdata;
  logic [AW-1:0]             raddr;
  localparam int unsigned LIM_W_C = ror_pkg::LIM_W + 1;
  logic [LIM_W_C-1:0]        rnew;
  logic                      keep;
  logic signed [7:0]         dx, dy;
  logic signed [15:0]        dxp, dyp;
  logic [ror_pkg::DIST_W-1:0] dist_sq;
  logic                      covers;

  assign op   = ror_pkg::op_t'(in_opcode);
  assign full = (count_r == DEPTH_C);

  // tick: grow by one and keep while within the limit
  assign rnew = {1'b0, rd_r.radius} + LIM_W_C'(1);
  assign keep = (rnew <= {1'b0, rd_r.limit});

  // table write port: add at capture, compaction during a tick walk
  always_comb begin
    we    = 1'b0;
    waddr = phys(head_r, kept_r);
    wdata = rd_r;
    wdata.radius = rnew[ror_pkg::LIM_W-1:0];
    if (cmd.capture && op == ror_pkg::OP_ADD) begin
      we           = 1'b1;
      waddr        = full ? head_r : phys(head_r, count_r);
      wdata.cx     = in_coord_x;
      wdata.cy     = in_coord_y;
      wdata.radius = '0;
      wdata.limit  = in_ring_limit;
      wdata.symbol = in_ring_symbol;
    end else if (v1_r && !query_r && keep) begin
      we = 1'b1;
    end
  end

  assign raddr = phys(head_r, idx_r);

  always_ff @(posedge clk) begin
    if (we) begin
      ring_mem[waddr] <= wdata;
    end
    if (cmd.issue) begin
      rd_r <= ring_mem[raddr];
    end
  end

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    if (cmd.capture && op == ror_pkg::OP_ADD) begin
      if (full) begin
        // drop the oldest ring by moving the start of the buffer
        head_nxt = (head_r == LAST_A) ? '0 : head_r + AW'(1);
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else if (cmd.capture && op == ror_pkg::OP_CLEAR) begin
      count_nxt = '0;
      head_nxt  = '0;
    end else if (cmd.finish && !query_r) begin
      count_nxt = kept_r;
    end
  end

  // query stage one: offsets squared and ring bounds
  assign dx  = $signed({1'b0, px_r}) - $signed({1'b0, rd_r.cx});
  assign dy  = 8'(signed'({3'b0, py_r}) - signed'({3'b0, rd_r.cy}));
  assign dxp = dx * dx;
  assign dyp = dy * dy;

  // query stage two: distance against the band
  assign dist_sq = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign covers  = (dist_sq >= ror_pkg::DIST_W'(lo_r)) &&
                   (dist_sq <= ror_pkg::DIST_W'(hi_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_r      <= '0;
      bg_r        <= ror_pkg::BG_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      query_r     <= 1'b0;
      idx_r       <= '0;
      kept_r      <= '0;
      hit_r       <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      v1_r        <= cmd.issue;
      v2_r        <= v1_r && query_r;
      out_valid_r <= cmd.finish && query_r;
      if (cfg_wr) begin
        bg_r <= cfg_data;
      end
      if (cmd.capture) begin
        query_r <= (op == ror_pkg::OP_QUERY);
        idx_r   <= '0;
        kept_r  <= '0;
        hit_r   <= 1'b0;
      end else begin
        if (cmd.issue) begin
          idx_r <= idx_r + CW'(1);
        end
        if (v1_r && !query_r && keep) begin
          kept_r <= kept_r + CW'(1);
        end
        if (v2_r && covers && field_ok_r) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r       <= in_coord_x;
      py_r       <= in_coord_y;
      field_ok_r <= ({1'b0, in_coord_x} < 8'(FIELD_WIDTH)) &&
                    ({1'b0, in_coord_y} < 6'(FIELD_HEIGHT));
    end
    if (v1_r) begin
      dx2_r  <= dxp[ror_pkg::SQ_W-1:0];
      dy2_r  <= dyp[ror_pkg::SQ_W-1:0];
      lo_r   <= ror_pkg::ring_lo(rd_r.radius);
      hi_r   <= ror_pkg::ring_hi(rd_r.radius);
      sym2_r <= rd_r.symbol;
    end
    // later entries win
    if (v2_r && covers && field_ok_r) begin
      hsym_r <= sym2_r;
    end
    if (cmd.finish) begin
      out_sym_r <= hit_r ? hsym_r : bg_r;
      out_hit_r <= hit_r;
    end
  end

  assign stat.count_zero = (count_r == '0);
  assign stat.last_issue = (idx_r == count_r - CW'(1));
  assign stat.pipe_empty = !v1_r && !v2_r;

  assign out_valid        = out_valid_r;
  assign out_pixel_symbol = out_sym_r;
  assign out_ring_hit     = out_hit_r;

endmodule

FILE: tb/sv/tb_ring_overlay_rasterizer.sv
`timescale 1ns / 1ps

module tb_ring_overlay_rasterizer;
  import ror_pkg::*;

  localparam int RING_DEPTH  = 64;
  localparam int FIELD_W     = 80;
  localparam int FIELD_H     = 24;
  localparam int CLK_PERIOD  = 10;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 355;
  localparam int FILL_BURST  = 70;
  localparam int OPENING_ROWS = 25;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             hit;
  } pixel_answer_t;

  typedef struct packed {
    op_t              op;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [SYM_W-1:0] sym;
    logic [LIM_W-1:0] lim;
    logic             typed;
    pixel_answer_t    answer;
  } opening_row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_opcode;
  logic [6:0]       in_coord_x;
  logic [4:0]       in_coord_y;
  logic [7:0]       in_ring_symbol;
  logic [3:0]       in_ring_limit;
  logic             out_valid;
  logic [7:0]       out_pixel_symbol;
  logic             out_ring_hit;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [7:0]       cfg_data;

  ring_entry_t      ring_book[$];
  pixel_answer_t    pending_pixels[$];
  pixel_answer_t    oldest_pixel;
  logic [SYM_W-1:0] background;
  int               idle_pct;
  int               error_count;

  ring_overlay_rasterizer #(
    .TABLE_DEPTH (RING_DEPTH),
    .FIELD_WIDTH (FIELD_W),
    .FIELD_HEIGHT(FIELD_H)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_ring_symbol  (in_ring_symbol),
    .in_ring_limit   (in_ring_limit),
    .out_valid       (out_valid),
    .out_pixel_symbol(out_pixel_symbol),
    .out_ring_hit    (out_ring_hit),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  // Short opening sequence; rows with typed set carry their own answer.
  opening_row_t opening_rows [OPENING_ROWS] = '{
    '{OP_QUERY, 7'd0,   5'd0,  8'h00, 4'd0,  1'b1, '{8'd32, 1'b0}},
    '{OP_ADD,   7'd10,  5'd10, 8'h41, 4'd0,  1'b0, '0},
    '{OP_QUERY, 7'd11,  5'd10, 8'h00, 4'd0,  1'b0, '0},
    '{OP_QUERY, 7'd10,  5'd10, 8'h00, 4'd0,  1'b0, '0},
    '{OP_TICK,  7'd5,   5'd7,  8'h99, 4'd9,  1'b0, '0},
    '{OP_QUERY, 7'd11,  5'd10, 8'h00, 4'd0,  1'b1, '{8'd32, 1'b0}},
    '{OP_ADD,   7'd127, 5'd31, 8'hFF, 4'd15, 1'b0, '0},
    '{OP_ADD,   7'd0,   5'd0,  8'h00, 4'd15, 1'b0, '0},
    '{OP_ADD,   7'd79,  5'd23, 8'h80, 4'd7,  1'b0, '0},
    '{OP_ADD,   7'd40,  5'd12, 8'h5A, 4'd3,  1'b0, '0},
    '{OP_TICK,  7'd0,   5'd0,  8'h00, 4'd0,  1'b0, '0},
    '{OP_TICK,  7'd127, 5'd31, 8'hFF, 4'd15, 1'b0, '0},
    '{OP_QUERY, 7'd79,  5'd21, 8'hFF, 4'd15, 1'b0, '0},
    '{OP_QUERY, 7'd40,  5'd24, 8'h00, 4'd0,  1'b1, '{8'd32, 1'b0}},
    '{OP_QUERY, 7'd80,  5'd0,  8'h00, 4'd0,  1'b1, '{8'd32, 1'b0}},
    '{OP_QUERY, 7'd127, 5'd31, 8'h00, 4'd0,  1'b1, '{8'd32, 1'b0}},
    '{OP_QUERY, 7'd2,   5'd0,  8'h00, 4'd0,  1'b0, '0},
    '{OP_QUERY, 7'd79,  5'd23, 8'h00, 4'd0,  1'b0, '0},
    '{OP_TICK,  7'd1,   5'd1,  8'h01, 4'd1,  1'b0, '0},
    '{OP_TICK,  7'd2,   5'd2,  8'h02, 4'd2,  1'b0, '0},
    '{OP_QUERY, 7'd42,  5'd12, 8'h00, 4'd0,  1'b0, '0},
    '{OP_CLEAR, 7'd127, 5'd31, 8'hFF, 4'd15, 1'b0, '0},
    '{OP_QUERY, 7'd11,  5'd10, 8'h00, 4'd0,  1'b1, '{8'd32, 1'b0}},
    '{OP_ADD,   7'd5,   5'd5,  8'h33, 4'd15, 1'b0, '0},
    '{OP_QUERY, 7'd6,   5'd5,  8'h00, 4'd0,  1'b0, '0}
  };

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // append a ring at radius 0; evict the oldest when the table is full
  function automatic void place_ring(logic [X_W-1:0] x, logic [Y_W-1:0] y,
                                     logic [SYM_W-1:0] sym, logic [LIM_W-1:0] lim);
    ring_entry_t e;
    if (ring_book.size() >= RING_DEPTH) void'(ring_book.pop_front());
    e = '{cx: x, cy: y, radius: '0, limit: lim, symbol: sym};
    ring_book.push_back(e);
  endfunction

  // grow every ring, retire those past their limit, keep the order
  function automatic void grow_rings();
    ring_entry_t kept[$];
    ring_entry_t e;
    foreach (ring_book[i]) begin
      e = ring_book[i];
      if (int'(e.radius) + 1 <= int'(e.limit)) begin
        e.radius = e.radius + 1'b1;
        kept.push_back(e);
      end
    end
    ring_book = kept;
  endfunction

  // newest covering ring wins
  function automatic pixel_answer_t pixel_lookup(logic [X_W-1:0] px, logic [Y_W-1:0] py);
    pixel_answer_t a;
    int dx;
    int dy;
    int dist_sq;
    int r;
    a.sym = background;
    a.hit = 1'b0;
    if (int'(px) < FIELD_W && int'(py) < FIELD_H) begin
      foreach (ring_book[i]) begin
        dx = int'(px) - int'(ring_book[i].cx);
        dy = int'(py) - int'(ring_book[i].cy);
        dist_sq = dx * dx + dy * dy;
        r = int'(ring_book[i].radius);
        if (dist_sq >= (r - 1) * (r - 1) && dist_sq <= (r + 1) * (r + 1)) begin
          a.sym = ring_book[i].symbol;
          a.hit = 1'b1;
        end
      end
    end
    return a;
  endfunction

  task automatic issue(input op_t op, input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                       input logic [SYM_W-1:0] sym, input logic [LIM_W-1:0] lim,
                       input logic typed, input pixel_answer_t typed_answer);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_coord_x     <= x;
    in_coord_y     <= y;
    in_ring_symbol <= sym;
    in_ring_limit  <= lim;
    do @(posedge clk); while (busy);
    case (op)
      OP_ADD:   place_ring(x, y, sym, lim);
      OP_CLEAR: ring_book.delete();
      OP_TICK:  grow_rings();
      OP_QUERY: pending_pixels.push_back(typed ? typed_answer : pixel_lookup(x, y));
      default: ;
    endcase
  endtask

  // hold off until every pending answer is back; optionally let a tick finish too
  task automatic settle(input bit full_quiet);
    start <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
    if (full_quiet) repeat (RING_DEPTH + 16) @(posedge clk);
  endtask

  task automatic write_background(input logic [SYM_W-1:0] value);
    settle(1'b1);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    background = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_add();
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    if ($urandom_range(0, 4) == 0) begin
      x = X_W'($urandom_range(0, 127));
      y = Y_W'($urandom_range(0, 31));
    end else begin
      x = X_W'($urandom_range(0, FIELD_W - 1));
      y = Y_W'($urandom_range(0, FIELD_H - 1));
    end
    issue(OP_ADD, x, y, SYM_W'($urandom_range(0, 255)), LIM_W'($urandom_range(0, 15)),
          1'b0, '0);
  endtask

  // aim most queries at the rim of a live ring
  task automatic random_query();
    int pick;
    int span;
    int qx;
    int qy;
    ring_entry_t e;
    pick = $urandom_range(0, 99);
    if (pick < 70 && ring_book.size() != 0) begin
      e = ring_book[$urandom_range(0, ring_book.size() - 1)];
      span = int'(e.radius) + 1;
      qx = int'(e.cx) + int'($urandom_range(0, 2 * span)) - span;
      qy = int'(e.cy) + int'($urandom_range(0, 2 * span)) - span;
      qx = (qx < 0) ? 0 : (qx > 127) ? 127 : qx;
      qy = (qy < 0) ? 0 : (qy > 31) ? 31 : qy;
    end else if (pick < 90) begin
      qx = $urandom_range(0, FIELD_W - 1);
      qy = $urandom_range(0, FIELD_H - 1);
    end else begin
      qx = $urandom_range(0, 127);
      qy = $urandom_range(0, 31);
    end
    issue(OP_QUERY, X_W'(qx), Y_W'(qy), SYM_W'($urandom_range(0, 255)),
          LIM_W'($urandom_range(0, 15)), 1'b0, '0);
  endtask

  initial begin
    int pick;
    logic [SYM_W-1:0] bg_value;
    int idle_plan [PHASES] = '{0, 64, 28, 0};

    error_count    = 0;
    idle_pct       = 0;
    background     = BG_RESET;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_opcode      <= OP_ADD;
    in_coord_x     <= '0;
    in_coord_y     <= '0;
    in_ring_symbol <= '0;
    in_ring_limit  <= '0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i])
      issue(opening_rows[i].op, opening_rows[i].x, opening_rows[i].y, opening_rows[i].sym,
            opening_rows[i].lim, opening_rows[i].typed, opening_rows[i].answer);

    for (int phase = 0; phase < PHASES; phase++) begin
      bg_value = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      write_background(bg_value);
      idle_pct = idle_plan[phase];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // overflow the table so the oldest rings get evicted
        if (n == PHASE_ITEMS / 3)
          repeat (FILL_BURST) random_add();
        if (n == PHASE_ITEMS / 2 || $urandom_range(0, 99) == 0)
          settle(1'b0);
        pick = $urandom_range(0, 99);
        if (pick < 35)
          random_add();
        else if (pick < 50)
          issue(OP_TICK, X_W'($urandom_range(0, 127)), Y_W'($urandom_range(0, 31)),
                SYM_W'($urandom_range(0, 255)), LIM_W'($urandom_range(0, 15)), 1'b0, '0);
        else if (pick < 52)
          issue(OP_CLEAR, X_W'($urandom_range(0, 127)), Y_W'($urandom_range(0, 31)),
                SYM_W'($urandom_range(0, 255)), LIM_W'($urandom_range(0, 15)), 1'b0, '0);
        else
          random_query();
      end
    end

    settle(1'b1);
    if (error_count == 0)
      $display("tb_ring_overlay_rasterizer: done, clean");
    else
      $display("tb_ring_overlay_rasterizer: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel answer with no query pending: symbol %0h hit %0b",
               out_pixel_symbol, out_ring_hit);
        error_count++;
      end else begin
        oldest_pixel = pending_pixels.pop_front();
        if (out_pixel_symbol !== oldest_pixel.sym) begin
          $error("pixel_symbol: expected %0h, got %0h", oldest_pixel.sym, out_pixel_symbol);
          error_count++;
        end
        if (out_ring_hit !== oldest_pixel.hit) begin
          $error("ring_hit: expected %0b, got %0b", oldest_pixel.hit, out_ring_hit);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("tb_ring_overlay_rasterizer: done, errors");
    $finish;
  end

endmodule

FILE: ring_overlay_rasterizer.f
rtl/ror_pkg.sv
rtl/ror_ctrl.sv
rtl/ror_datapath.sv
rtl/ring_overlay_rasterizer.sv
tb/sv/tb_ring_overlay_rasterizer.sv
